// ===== rtl/csm_pkg.sv =====
// ----------------------------------------------------------------------------
// csm_pkg
// Shared constants and types for the contiguous subsequence match block.
// ----------------------------------------------------------------------------
package csm_pkg;

  localparam int MAX_PATTERN = 128;
  localparam int VALUE_BITS  = 32;

  // element port width is fixed, compare at most that many bits
  localparam int DATA_W = 32;
  localparam int CMP_W  = (VALUE_BITS < DATA_W) ? VALUE_BITS : DATA_W;

  localparam int IDX_W = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
  localparam int LEN_W = $clog2(MAX_PATTERN + 1);

  // element kinds carried on tuser
  localparam logic OP_PATTERN = 1'b0;
  localparam logic OP_TEXT    = 1'b1;

  // broadcast to every cell of the chain
  typedef struct packed {
    logic             write;  // store value into the cell at wr_idx
    logic             text;   // advance the match bits with value
    logic             clear;  // drop all partial matches
    logic [IDX_W-1:0] wr_idx;
    logic [CMP_W-1:0] value;
  } csm_ctrl_t;

endpackage

// ===== rtl/contiguous_subsequence_match.sv =====
// ----------------------------------------------------------------------------
// contiguous_subsequence_match
// Shift-and substring search over a row of pattern cells; one verdict per text.
// ----------------------------------------------------------------------------
//  channel  dir  tdata                      tuser      tlast
//  s_*      in   [31:0] value               operation  last element
//  m_*      out  [0] found, [1] overflow    -          -
//
//  one element per cycle, pattern or text; each text element is compared
//  against every cell in the same cycle and the match bits step one cell
//  down the chain. the verdict is loaded into the output register when the
//  final text element is taken. reset clears length, flags and match bits; the
//  stored pattern elements are not cleared. input is stalled only while a
//  verdict waits in the output register and m_tready is low.
// ----------------------------------------------------------------------------
module contiguous_subsequence_match (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // [31:0] value
  input  logic        s_tuser,   // [0] operation
  input  logic        s_tlast,   // [0] last
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata    // [0] found, [1] pattern_overflow, [7:2] zero
);

  localparam int MAXP = csm_pkg::MAX_PATTERN;

  logic [csm_pkg::LEN_W-1:0] pattern_length;
  logic [csm_pkg::LEN_W-1:0] pattern_length_next;
  logic [csm_pkg::LEN_W-1:0] len_base;
  logic                      pattern_open;
  logic                      overflow_flag;
  logic                      overflow_base;
  logic                      found_flag;
  logic                      found_now;
  logic                      s_fire;
  logic                      is_text;
  logic                      is_load;
  logic                      room;
  logic                      found_out;
  logic                      overflow_out;
  csm_pkg::csm_ctrl_t        ctrl;
  logic [MAXP-1:0]           match;
  logic [MAXP-1:0]           hit;

  assign s_tready = !m_tvalid || m_tready;
  assign s_fire   = s_tvalid && s_tready;
  assign is_text  = s_fire && (s_tuser == csm_pkg::OP_TEXT);
  assign is_load  = s_fire && (s_tuser == csm_pkg::OP_PATTERN);

  // a pattern element with no pattern open starts a fresh pattern
  assign len_base      = pattern_open ? pattern_length : '0;
  assign overflow_base = pattern_open && overflow_flag;
  assign room          = (len_base < csm_pkg::LEN_W'(MAXP));
  assign pattern_length_next = len_base + csm_pkg::LEN_W'(1);

  always_comb begin
    ctrl.write  = is_load && room;
    ctrl.text   = is_text;
    ctrl.clear  = (is_load && !pattern_open) || (is_text && s_tlast);
    ctrl.wr_idx = len_base[csm_pkg::IDX_W-1:0];
    ctrl.value  = s_tdata[csm_pkg::CMP_W-1:0];
  end

  genvar k;
  generate
    for (k = 0; k < MAXP; k++) begin : g_chain
      logic prev;
      if (k == 0) begin : g_head
        assign prev = 1'b1;
      end else begin : g_link
        assign prev = match[k-1];
      end
      csm_cell u_cell (
        .clk        (clk),
        .rst        (rst),
        .index      (csm_pkg::IDX_W'(k)),
        .ctrl       (ctrl),
        .prev_match (prev),
        .match      (match[k]),
        .hit        (hit[k])
      );
    end
  endgenerate

  // empty pattern matches every text element
  assign found_now = found_flag || (pattern_length == '0) || (|hit);

  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_length <= '0;
      pattern_open   <= 1'b0;
      overflow_flag  <= 1'b0;
      found_flag     <= 1'b0;
      m_tvalid       <= 1'b0;
    end else begin
      if (is_text && s_tlast) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      if (is_load) begin
        pattern_length <= room ? pattern_length_next : len_base;
        overflow_flag  <= overflow_base || !room;
        pattern_open   <= !s_tlast;
        if (!pattern_open) begin
          found_flag <= 1'b0;
        end
      end else if (is_text) begin
        pattern_open <= 1'b0;
        if (s_tlast) begin
          found_flag <= 1'b0;
        end else begin
          found_flag <= found_now;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (is_text && s_tlast) begin
      found_out    <= found_now;
      overflow_out <= overflow_flag;
    end
  end

  assign m_tdata = {6'b0, overflow_out, found_out};

  // assertions

  assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(s_fire && s_tuser == csm_pkg::OP_TEXT && s_tlast))
    else $error("verdict without a final text transaction");

  assert property (@(posedge clk) disable iff (rst)
    pattern_length <= csm_pkg::LEN_W'(MAXP))
    else $error("pattern length beyond capacity");

  assert property (@(posedge clk) disable iff (rst)
    overflow_flag |-> pattern_length == csm_pkg::LEN_W'(MAXP))
    else $error("overflow flagged on a pattern that is not full");

  assert property (@(posedge clk) disable iff (rst)
    (is_text && s_tlast && pattern_length == '0) |=> (m_tvalid && m_tdata[0]))
    else $error("empty pattern did not report a match");

endmodule

// ===== rtl/csm_cell.sv =====
// ----------------------------------------------------------------------------
// csm_cell
// One pattern position: holds its element, an end-of-pattern mark and the
// match bit of the prefix ending here, taking the neighbour's bit on each text element.
// ----------------------------------------------------------------------------
module csm_cell (
  input  logic                      clk,
  input  logic                      rst,
  input  logic [csm_pkg::IDX_W-1:0] index,
  input  csm_pkg::csm_ctrl_t        ctrl,
  input  logic                      prev_match,
  output logic                      match,
  output logic                      hit
);

  logic [csm_pkg::CMP_W-1:0] element;
  logic                      tail;
  logic                      match_next;
  logic                      selected;

  assign selected   = (ctrl.wr_idx == index);
  assign match_next = prev_match && (element == ctrl.value);
  // whole pattern ends at this text transaction
  assign hit        = ctrl.text && tail && match_next;

  always_ff @(posedge clk) begin
    if (ctrl.write && selected) begin
      element <= ctrl.value;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tail  <= 1'b0;
      match <= 1'b0;
    end else begin
      if (ctrl.write) begin
        tail <= selected;
      end
      if (ctrl.clear) begin
        match <= 1'b0;
      end else if (ctrl.text) begin
        match <= match_next;
      end
    end
  end

endmodule
